FILE: hdl/ptifd_pkg.sv
// Shared widths, codes and controller/datapath interface types for the packed table unit.
package ptifd_pkg;

    // fixed word field widths
    localparam int OP_W          = 2;
    localparam int ID_FIELD_W    = 16;
    localparam int PRICE_FIELD_W = 16;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 5;

    // parameter defaults
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 16;
    localparam int PRICE_WIDTH_DEF = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd2;
    localparam logic [OP_W-1:0] OP_AVERAGE = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd3;

    typedef struct packed {
        logic                latch;      // take key, restart scan pointer
        logic                insert;     // append entry at fill position
        logic                step;       // issue next table read
        logic                shift_wr;   // write returned entry one place down
        logic                capture;    // hold matched price
        logic                sub_total;  // remove matched price from total
        logic                dec_fill;
        logic                div_start;
        logic                div_step;
        logic                emit;       // load output register
        logic                emit_found;
        logic                emit_avg;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic match;
        logic scan_end;
        logic div_done;
        logic out_busy;
    } stat_t;

endpackage

FILE: hdl/packed_table_insert_find_delete_unit.sv
// Packed (id, price) table: insert appends, lookup and delete find the first matching id
// by a scan of the table RAM at one entry a cycle (delete then moves later entries down,
// again one a cycle), and average divides the running price total by the count with a
// restoring divider, one quotient bit a cycle. One word is in work at a time; the result
// register lets the finished word wait while the next one is accepted.
module packed_table_insert_find_delete_unit #(
    parameter int TABLE_DEPTH = ptifd_pkg::TABLE_DEPTH_DEF,
    parameter int ID_WIDTH    = ptifd_pkg::ID_WIDTH_DEF,
    parameter int PRICE_WIDTH = ptifd_pkg::PRICE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ptifd_pkg::OP_W-1:0]           s_op,
    input  logic [ptifd_pkg::ID_FIELD_W-1:0]     s_entry_id,
    input  logic [ptifd_pkg::PRICE_FIELD_W-1:0]  s_entry_price,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ptifd_pkg::STATUS_W-1:0]       m_status,
    output logic [ptifd_pkg::PRICE_FIELD_W-1:0]  m_found_price,
    output logic [ptifd_pkg::PRICE_FIELD_W-1:0]  m_average_price,
    output logic [ptifd_pkg::COUNT_FIELD_W-1:0]  m_entry_count
);

    ptifd_pkg::cmd_t  cmd;
    ptifd_pkg::stat_t stat;

    ptifd_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op   (s_op),
        .stat   (stat),
        .cmd    (cmd)
    );

    ptifd_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .ID_WIDTH   (ID_WIDTH),
        .PRICE_WIDTH(PRICE_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_entry_id     (s_entry_id),
        .s_entry_price  (s_entry_price),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_found_price  (m_found_price),
        .m_average_price(m_average_price),
        .m_entry_count  (m_entry_count)
    );

endmodule

FILE: hdl/ptifd_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ptifd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/ptifd_ctrl.sv
// Sequencing state machine for the packed table unit.
module ptifd_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ptifd_pkg::OP_W-1:0]       s_op,
    input  ptifd_pkg::stat_t                 stat,
    output ptifd_pkg::cmd_t                  cmd
);

    typedef enum logic [2:0] {
        IDLE,
        SCAN,
        SHIFT,
        DIVIDE,
        DONE
    } state_t;

    state_t                           state_reg, state_next;
    logic [ptifd_pkg::OP_W-1:0]       op_reg, op_next;
    logic [ptifd_pkg::STATUS_W-1:0]   status_reg, status_next;

    assign s_ready = (state_reg == IDLE);

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        op_next     = op_reg;
        status_next = status_reg;
        cmd.status  = status_reg;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.latch   = 1'b1;
                    op_next     = s_op;
                    status_next = ptifd_pkg::STS_OK;
                    unique case (s_op)
                        ptifd_pkg::OP_INSERT: begin
                            if (stat.full) begin
                                status_next = ptifd_pkg::STS_FULL;
                            end else begin
                                cmd.insert = 1'b1;
                            end
                            state_next = DONE;
                        end
                        ptifd_pkg::OP_LOOKUP,
                        ptifd_pkg::OP_DELETE: begin
                            state_next = SCAN;
                        end
                        default: begin
                            if (stat.empty) begin
                                status_next = ptifd_pkg::STS_EMPTY;
                                state_next  = DONE;
                            end else begin
                                cmd.div_start = 1'b1;
                                state_next    = DIVIDE;
                            end
                        end
                    endcase
                end
            end
            SCAN: begin
                cmd.step = 1'b1;
                priority if (stat.match) begin
                    if (op_reg == ptifd_pkg::OP_DELETE) begin
                        cmd.sub_total = 1'b1;
                        state_next    = SHIFT;
                    end else begin
                        cmd.capture = 1'b1;
                        state_next  = DONE;
                    end
                end else if (stat.scan_end) begin
                    status_next = ptifd_pkg::STS_NOT_FOUND;
                    state_next  = DONE;
                end
            end
            SHIFT: begin
                // reads run one ahead of the writes back one place down;
                // an entry is back from the table every cycle until the scan runs out
                cmd.step     = 1'b1;
                cmd.shift_wr = ~stat.scan_end;
                if (stat.scan_end) begin
                    cmd.dec_fill = 1'b1;
                    state_next   = DONE;
                end
            end
            DIVIDE: begin
                if (stat.div_done) begin
                    state_next = DONE;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            DONE: begin
                if (!stat.out_busy) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_found = (op_reg == ptifd_pkg::OP_LOOKUP) &&
                                     (status_reg == ptifd_pkg::STS_OK);
                    cmd.emit_avg   = (op_reg == ptifd_pkg::OP_AVERAGE) &&
                                     (status_reg == ptifd_pkg::STS_OK);
                    state_next     = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= IDLE;
            op_reg     <= ptifd_pkg::OP_INSERT;
            status_reg <= ptifd_pkg::STS_OK;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            status_reg <= status_next;
        end
    end

endmodule

FILE: hdl/ptifd_datapath.sv
// Table storage, scan pointer, running total, divider and output register.
module ptifd_datapath #(
    parameter int TABLE_DEPTH = ptifd_pkg::TABLE_DEPTH_DEF,
    parameter int ID_WIDTH    = ptifd_pkg::ID_WIDTH_DEF,
    parameter int PRICE_WIDTH = ptifd_pkg::PRICE_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [ptifd_pkg::ID_FIELD_W-1:0]       s_entry_id,
    input  logic [ptifd_pkg::PRICE_FIELD_W-1:0]    s_entry_price,
    input  ptifd_pkg::cmd_t                        cmd,
    output ptifd_pkg::stat_t                       stat,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [ptifd_pkg::STATUS_W-1:0]         m_status,
    output logic [ptifd_pkg::PRICE_FIELD_W-1:0]    m_found_price,
    output logic [ptifd_pkg::PRICE_FIELD_W-1:0]    m_average_price,
    output logic [ptifd_pkg::COUNT_FIELD_W-1:0]    m_entry_count
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int TW  = PRICE_WIDTH + CW;
    localparam int DCW = $clog2(TW + 1);
    localparam int EW  = ID_WIDTH + PRICE_WIDTH;

    logic [ID_WIDTH-1:0]    key_in;
    logic [PRICE_WIDTH-1:0] price_in;

    logic [ID_WIDTH-1:0]    key_reg, key_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          pidx_reg, pidx_next;
    logic                   pend_reg, pend_next;
    logic [PRICE_WIDTH-1:0] hold_reg, hold_next;
    logic [CW:0]            rem_reg, rem_next;
    logic [TW-1:0]          quo_reg, quo_next;
    logic [DCW-1:0]         dcnt_reg, dcnt_next;

    logic                   m_valid_reg, m_valid_next;
    logic [ptifd_pkg::STATUS_W-1:0]      m_status_reg, m_status_next;
    logic [ptifd_pkg::PRICE_FIELD_W-1:0] m_found_reg, m_found_next;
    logic [ptifd_pkg::PRICE_FIELD_W-1:0] m_avg_reg, m_avg_next;
    logic [ptifd_pkg::COUNT_FIELD_W-1:0] m_count_reg, m_count_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [EW-1:0]          ram_wdata;
    logic [EW-1:0]          ram_rdata;
    logic [ID_WIDTH-1:0]    q_id;
    logic [PRICE_WIDTH-1:0] q_price;
    logic [CW-1:0]          wr_back;
    logic                   issue;
    logic [CW:0]            trial;
    logic                   trial_ge;

    assign key_in   = ID_WIDTH'(s_entry_id);
    assign price_in = PRICE_WIDTH'(s_entry_price);
    assign q_id     = ram_rdata[PRICE_WIDTH +: ID_WIDTH];
    assign q_price  = ram_rdata[PRICE_WIDTH-1:0];
    assign wr_back  = pidx_reg - CW'(1);
    assign issue    = cmd.step && (idx_reg < fill_reg);

    // divider trial: shift in next dividend bit, compare with the count
    assign trial    = {rem_reg[CW-1:0], quo_reg[TW-1]};
    assign trial_ge = (trial >= {1'b0, fill_reg});

    always_comb begin
        if (cmd.insert) begin
            ram_we    = 1'b1;
            ram_waddr = fill_reg[AW-1:0];
            ram_wdata = {key_in, price_in};
        end else begin
            ram_we    = cmd.shift_wr;
            ram_waddr = wr_back[AW-1:0];
            ram_wdata = ram_rdata;
        end
    end

    ptifd_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    assign stat.full     = (fill_reg == CW'(TABLE_DEPTH));
    assign stat.empty    = (fill_reg == '0);
    assign stat.match    = pend_reg && (q_id == key_reg);
    assign stat.scan_end = !pend_reg && (idx_reg >= fill_reg);
    assign stat.div_done = (dcnt_reg == '0);
    assign stat.out_busy = m_valid_reg && !m_ready;

    always_comb begin
        key_next   = key_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        pidx_next  = pidx_reg;
        pend_next  = issue;
        hold_next  = hold_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dcnt_next  = dcnt_reg;

        if (cmd.latch) begin
            key_next = key_in;
            idx_next = '0;
        end else if (issue) begin
            idx_next  = idx_reg + CW'(1);
            pidx_next = idx_reg;
        end
        if (cmd.insert) begin
            fill_next  = fill_reg + CW'(1);
            total_next = total_reg + TW'(price_in);
        end
        if (cmd.sub_total) begin
            total_next = total_reg - TW'(q_price);
        end
        if (cmd.dec_fill) begin
            fill_next = fill_reg - CW'(1);
        end
        if (cmd.capture) begin
            hold_next = q_price;
        end
        if (cmd.div_start) begin
            rem_next  = '0;
            quo_next  = total_reg;
            dcnt_next = DCW'(TW);
        end else if (cmd.div_step) begin
            rem_next  = trial_ge ? (trial - {1'b0, fill_reg}) : trial;
            quo_next  = {quo_reg[TW-2:0], trial_ge};
            dcnt_next = dcnt_reg - DCW'(1);
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_avg_next    = m_avg_reg;
        m_count_next  = m_count_reg;
        if (cmd.emit) begin
            m_valid_next  = 1'b1;
            m_status_next = cmd.status;
            m_found_next  = cmd.emit_found ? ptifd_pkg::PRICE_FIELD_W'(hold_reg) : '0;
            m_avg_next    = cmd.emit_avg ? ptifd_pkg::PRICE_FIELD_W'(quo_reg) : '0;
            m_count_next  = ptifd_pkg::COUNT_FIELD_W'(fill_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            total_reg   <= '0;
            pend_reg    <= 1'b0;
            idx_reg     <= '0;
            dcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            total_reg   <= total_next;
            pend_reg    <= pend_next;
            idx_reg     <= idx_next;
            dcnt_reg    <= dcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        pidx_reg     <= pidx_next;
        hold_reg     <= hold_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_avg_reg    <= m_avg_next;
        m_count_reg  <= m_count_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_found_price   = m_found_reg;
    assign m_average_price = m_avg_reg;
    assign m_entry_count   = m_count_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_total_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0) |-> (total_reg == '0))
        else $error("price total not zero on empty table");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_valid_reg && !m_ready))
        else $error("result word overwritten while still held");

    a_shift_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_wr |-> (pend_reg && (pidx_reg != '0) && (pidx_reg < fill_reg)))
        else $error("shift write outside live region");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the packed table unit: predicts every result and checks it in order.
`timescale 1ns / 100ps

module tb_top;

    localparam int DEPTH          = ptifd_pkg::TABLE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct packed {
        logic [ptifd_pkg::STATUS_W-1:0]      status;
        logic [ptifd_pkg::PRICE_FIELD_W-1:0] found_price;
        logic [ptifd_pkg::PRICE_FIELD_W-1:0] average_price;
        logic [ptifd_pkg::COUNT_FIELD_W-1:0] entry_count;
    } table_result_t;

    logic                                 aclk          = 1'b0;
    logic                                 aresetn       = 1'b0;
    logic                                 s_valid       = 1'b0;
    logic                                 s_ready;
    logic [ptifd_pkg::OP_W-1:0]           s_op          = ptifd_pkg::OP_INSERT;
    logic [ptifd_pkg::ID_FIELD_W-1:0]     s_entry_id    = '0;
    logic [ptifd_pkg::PRICE_FIELD_W-1:0]  s_entry_price = '0;
    logic                                 m_valid;
    logic                                 m_ready       = 1'b0;
    logic [ptifd_pkg::STATUS_W-1:0]       m_status;
    logic [ptifd_pkg::PRICE_FIELD_W-1:0]  m_found_price;
    logic [ptifd_pkg::PRICE_FIELD_W-1:0]  m_average_price;
    logic [ptifd_pkg::COUNT_FIELD_W-1:0]  m_entry_count;

    // shadow copy of the table
    logic [ptifd_pkg::ID_FIELD_W-1:0]     shadow_id [DEPTH];
    logic [ptifd_pkg::PRICE_FIELD_W-1:0]  shadow_price [DEPTH];
    int                                   shadow_fill  = 0;
    int unsigned                          shadow_total = 0;

    table_result_t             pending_results [$];
    int                        src_idle_pct  = 0;
    int                        sink_idle_pct = 0;
    int                        err_count     = 0;
    int                        words_sent    = 0;
    int                        results_seen  = 0;
    int                        full_hits     = 0;
    int                        stall_cycles;

    packed_table_insert_find_delete_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_entry_id      (s_entry_id),
        .s_entry_price   (s_entry_price),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found_price   (m_found_price),
        .m_average_price (m_average_price),
        .m_entry_count   (m_entry_count)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // applies one word to the shadow table and returns the result it should give
    function automatic table_result_t apply_table_op(
        input logic [ptifd_pkg::OP_W-1:0]          op,
        input logic [ptifd_pkg::ID_FIELD_W-1:0]    id,
        input logic [ptifd_pkg::PRICE_FIELD_W-1:0] price);
        table_result_t r;
        int            pos;
        r        = '0;
        r.status = ptifd_pkg::STS_OK;
        pos      = -1;
        case (op)
            ptifd_pkg::OP_INSERT: begin
                if (shadow_fill < DEPTH) begin
                    shadow_id[shadow_fill]    = id;
                    shadow_price[shadow_fill] = price;
                    shadow_fill++;
                    shadow_total += price;
                end else begin
                    r.status = ptifd_pkg::STS_FULL;
                end
            end
            ptifd_pkg::OP_LOOKUP, ptifd_pkg::OP_DELETE: begin
                for (int i = 0; i < shadow_fill; i++) begin
                    if (pos < 0 && shadow_id[i] == id) pos = i;
                end
                if (pos < 0) begin
                    r.status = ptifd_pkg::STS_NOT_FOUND;
                end else if (op == ptifd_pkg::OP_LOOKUP) begin
                    r.found_price = shadow_price[pos];
                end else begin
                    shadow_total -= shadow_price[pos];
                    for (int i = pos; i + 1 < shadow_fill; i++) begin
                        shadow_id[i]    = shadow_id[i + 1];
                        shadow_price[i] = shadow_price[i + 1];
                    end
                    shadow_fill--;
                end
            end
            default: begin
                if (shadow_fill == 0) r.status = ptifd_pkg::STS_EMPTY;
                else r.average_price =
                    ptifd_pkg::PRICE_FIELD_W'(shadow_total / shadow_fill);
            end
        endcase
        r.entry_count = ptifd_pkg::COUNT_FIELD_W'(shadow_fill);
        return r;
    endfunction

    task automatic send_word(input logic [ptifd_pkg::OP_W-1:0]          op,
                             input logic [ptifd_pkg::ID_FIELD_W-1:0]    id,
                             input logic [ptifd_pkg::PRICE_FIELD_W-1:0] price);
        table_result_t r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_entry_id    <= id;
        s_entry_price <= price;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = apply_table_op(op, id, price);
        if (r.status == ptifd_pkg::STS_FULL) full_hits++;
        pending_results.push_back(r);
        words_sent++;
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_table_quiet();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    always @(posedge aclk) begin
        table_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: status %0d count %0d",
                       m_status, m_entry_count);
                err_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, m_status);
                    err_count++;
                end
                if (m_found_price !== exp_r.found_price) begin
                    $error("found_price: expected %0d, actual %0d",
                           exp_r.found_price, m_found_price);
                    err_count++;
                end
                if (m_average_price !== exp_r.average_price) begin
                    $error("average_price: expected %0d, actual %0d",
                           exp_r.average_price, m_average_price);
                    err_count++;
                end
                if (m_entry_count !== exp_r.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           exp_r.entry_count, m_entry_count);
                    err_count++;
                end
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic test_empty_table();
        send_word(ptifd_pkg::OP_AVERAGE, 16'h0000, 16'hFFFF);
        send_word(ptifd_pkg::OP_LOOKUP, 16'h0000, 16'h0000);
        send_word(ptifd_pkg::OP_DELETE, 16'hFFFF, 16'h1234);
        wait_table_quiet();
    endtask

    task automatic test_field_extremes();
        send_word(ptifd_pkg::OP_INSERT, 16'h0000, 16'h0000);
        send_word(ptifd_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF);
        send_word(ptifd_pkg::OP_LOOKUP, 16'hFFFF, 16'h0000);
        send_word(ptifd_pkg::OP_LOOKUP, 16'h0000, 16'hFFFF);
        send_word(ptifd_pkg::OP_AVERAGE, 16'h5555, 16'hAAAA);
        wait_table_quiet();
    endtask

    task automatic test_duplicate_ids();
        send_word(ptifd_pkg::OP_INSERT, 16'h0007, 16'd100);
        send_word(ptifd_pkg::OP_INSERT, 16'h0007, 16'd200);
        send_word(ptifd_pkg::OP_LOOKUP, 16'h0007, 16'h0000);
        send_word(ptifd_pkg::OP_DELETE, 16'h0007, 16'h0000);
        send_word(ptifd_pkg::OP_LOOKUP, 16'h0007, 16'h0000);
        wait_table_quiet();
    endtask

    // fill the free slots with top prices to push the running total towards its widest
    task automatic test_full_table();
        while (shadow_fill < DEPTH) begin
            send_word(ptifd_pkg::OP_INSERT,
                      ptifd_pkg::ID_FIELD_W'(16'h8000 + shadow_fill), 16'hFFFF);
        end
        send_word(ptifd_pkg::OP_INSERT, 16'h1111, 16'h2222);
        send_word(ptifd_pkg::OP_AVERAGE, 16'h0000, 16'h0000);
        send_word(ptifd_pkg::OP_DELETE, 16'h8005, 16'h0000);
        wait_table_quiet();
    endtask

    function automatic logic [ptifd_pkg::ID_FIELD_W-1:0] pick_key(input int live_pct);
        int r;
        r = $urandom_range(0, 99);
        if (shadow_fill > 0 && r < live_pct)
            return shadow_id[$urandom_range(0, shadow_fill - 1)];
        else if (r < live_pct + (100 - live_pct) / 2)
            return ptifd_pkg::ID_FIELD_W'($urandom_range(0, 15));
        return ptifd_pkg::ID_FIELD_W'($urandom);
    endfunction

    task automatic test_random_mix(input int n_words);
        int                                  r;
        int                                  ins_pct;
        logic [ptifd_pkg::OP_W-1:0]          op;
        logic [ptifd_pkg::ID_FIELD_W-1:0]    id;
        logic [ptifd_pkg::PRICE_FIELD_W-1:0] price;
        for (int k = 0; k < n_words; k++) begin
            ins_pct = (shadow_fill <= 12) ? 55 : 40;
            r = $urandom_range(0, 99);
            if (r < ins_pct) begin
                op = ptifd_pkg::OP_INSERT;
                id = pick_key(30);
            end else begin
                r  = $urandom_range(0, 99);
                op = (r < 40) ? ptifd_pkg::OP_LOOKUP :
                     (r < 80) ? ptifd_pkg::OP_DELETE : ptifd_pkg::OP_AVERAGE;
                id = pick_key(60);
            end
            r = $urandom_range(0, 9);
            price = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
                    ptifd_pkg::PRICE_FIELD_W'($urandom);
            send_word(op, id, price);
            if (k % 200 == 199) wait_table_quiet();
        end
        wait_table_quiet();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct  = 31;
        sink_idle_pct = 81;
        test_empty_table();
        test_field_extremes();
        test_duplicate_ids();
        test_full_table();
        test_random_mix(540);

        src_idle_pct  = 81;
        sink_idle_pct = 31;
        test_random_mix(540);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_mix(545);

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d words, checked %0d results (%0d against a full table), %0d errors.",
                 words_sent, results_seen, full_hits, err_count);
        $display("Covered empty, full, duplicate-id and extreme values under three idle mixes.");
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
